@@ src/variable_bit_packer_defines.svh @@
// Assertion helpers shared by the packer modules.
`ifndef VARIABLE_BIT_PACKER_DEFINES_SVH
`define VARIABLE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define VBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vbp check failed");

// Next-cycle implication, checked out of reset only.
`define VBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbp check failed");

`endif

@@ src/vbp_pkg.sv @@
package vbp_pkg;

    localparam int DATA_W        = 64;
    localparam int CNT_W         = 7;
    localparam int DEF_WORD_BITS = 64;
    localparam int Q_DEPTH       = 4;
    localparam int PUSH_W        = 2;

    typedef struct packed {
        logic [DATA_W-1:0] packed_word;
        logic [CNT_W-1:0]  bits_used;
        logic              final_res;
    } t_result;

    // Up to two results produced by one item, in stream order.
    typedef struct packed {
        logic [PUSH_W-1:0] cnt;
        t_result           r0;
        t_result           r1;
    } t_push;

    function automatic logic [DATA_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        if (n >= CNT_W'(DATA_W)) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << n) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

@@ src/vbp_in_if.sv @@
interface vbp_in_if;
    logic                         valid;
    logic                         ready;
    logic [vbp_pkg::DATA_W-1:0]   chunk;
    logic [vbp_pkg::CNT_W-1:0]    chunk_bits;
    logic                         end_of_string;

    modport source (output valid, chunk, chunk_bits, end_of_string, input ready);
    modport sink   (input valid, chunk, chunk_bits, end_of_string, output ready);
endinterface

@@ src/vbp_out_if.sv @@
interface vbp_out_if;
    logic                         valid;
    logic                         ready;
    logic [vbp_pkg::DATA_W-1:0]   packed_word;
    logic [vbp_pkg::CNT_W-1:0]    bits_used;
    logic                         final_res;

    modport source (output valid, packed_word, bits_used, final_res, input ready);
    modport sink   (input valid, packed_word, bits_used, final_res, output ready);
endinterface

@@ src/vbp_core.sv @@
`include "variable_bit_packer_defines.svh"

module vbp_core #(
    parameter int WORD_BITS = vbp_pkg::DEF_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [vbp_pkg::DATA_W-1:0] i_chunk,
    input  logic [vbp_pkg::CNT_W-1:0]  i_chunk_bits,
    input  logic                       i_end,
    output vbp_pkg::t_push             o_push
);

    localparam int CW    = vbp_pkg::CNT_W;
    localparam int DW    = vbp_pkg::DATA_W;
    localparam int OFF_W = $clog2(WORD_BITS);
    localparam logic [CW-1:0] W_CNT = CW'(WORD_BITS);

    logic [WORD_BITS-1:0] r_part, n_part;
    logic [OFF_W-1:0]     r_off, n_off;

    logic [CW-1:0]        nbits;
    logic [DW-1:0]        chunk_mask;
    logic [WORD_BITS-1:0] data;
    logic [CW-1:0]        sum;
    logic [CW-1:0]        rest;
    logic                 full;
    logic [WORD_BITS-1:0] merged;
    logic [WORD_BITS-1:0] spill;
    logic [WORD_BITS-1:0] step_part;
    logic [OFF_W-1:0]     step_off;
    logic [DW-1:0]        off_mask;
    vbp_pkg::t_result     full_res;
    vbp_pkg::t_result     tail_res;

    assign nbits      = (i_chunk_bits > W_CNT) ? W_CNT : i_chunk_bits;
    assign chunk_mask = vbp_pkg::low_mask(nbits);
    assign data       = i_chunk[WORD_BITS-1:0] & chunk_mask[WORD_BITS-1:0];
    assign sum        = CW'(r_off) + nbits;
    assign full       = (sum >= W_CNT);
    assign rest       = sum - W_CNT;
    assign merged     = r_part | (data << r_off);
    // bits past the word end start the next word; data is already masked to nbits
    assign spill      = (r_off == '0) ? '0 : (data >> (W_CNT - CW'(r_off)));
    assign step_part  = full ? spill : merged;
    assign step_off   = full ? rest[OFF_W-1:0] : sum[OFF_W-1:0];
    assign off_mask   = vbp_pkg::low_mask(CW'(r_off));

    always_comb begin
        full_res.packed_word = DW'(merged);
        full_res.bits_used   = W_CNT;
        full_res.final_res   = i_end && (rest == '0);

        tail_res.packed_word = DW'(step_part);
        tail_res.bits_used   = CW'(step_off);
        tail_res.final_res   = 1'b1;

        o_push.cnt = '0;
        o_push.r0  = full_res;
        o_push.r1  = tail_res;
        if (i_fire) begin
            if (full) begin
                o_push.cnt = (i_end && step_off != '0) ? 2'd2 : 2'd1;
            end else if (i_end && step_off != '0) begin
                o_push.cnt = 2'd1;
                o_push.r0  = tail_res;
            end
        end

        n_part = r_part;
        n_off  = r_off;
        if (i_fire) begin
            if (i_end) begin
                n_part = '0;
                n_off  = '0;
            end else begin
                n_part = step_part;
                n_off  = step_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_off  <= '0;
        end else begin
            r_part <= n_part;
            r_off  <= n_off;
        end
    end

    `VBP_ASSERT_IMP(a_off_range, i_clk, i_rst_n, 1'b1, CW'(r_off) < W_CNT)
    `VBP_ASSERT_IMP(a_part_clean, i_clk, i_rst_n, 1'b1,
                    (r_part & ~off_mask[WORD_BITS-1:0]) == '0)
    `VBP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_fire && i_end,
                     r_off == '0 && r_part == '0)

endmodule

@@ src/vbp_queue.sv @@
`include "variable_bit_packer_defines.svh"

module vbp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vbp_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output vbp_pkg::t_result  o_res
);

    localparam int DEPTH = vbp_pkg::Q_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CQ_W  = $clog2(DEPTH + 1);

    vbp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CQ_W-1:0]  r_cnt, n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // room for the worst case of two results from one item
    assign o_room  = (r_cnt <= CQ_W'(DEPTH - 2));

    always_comb begin
        n_wp  = r_wp + PTR_W'(i_push.cnt);
        n_rp  = r_rp + PTR_W'(pop);
        n_cnt = r_cnt + CQ_W'(i_push.cnt) - CQ_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != '0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.r1;
        end
    end

    `VBP_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CQ_W'(DEPTH))
    `VBP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push.cnt != '0, o_room)
    `VBP_ASSERT_NEXT(a_head_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

endmodule

@@ src/variable_bit_packer.sv @@
// Variable-length bit packer.
// Input channel i_in carries a chunk of up to 64 bits, its bit count
// (chunk_bits, counts above WORD_BITS saturate) and end_of_string. Chunks are
// appended LSB first to a stream cut into WORD_BITS-bit words.
// Output channel o_out carries packed_word, bits_used and final_res. A word
// leaves each time WORD_BITS bits have gathered; end_of_string flushes the
// partial word (zero above bits_used) marked final, or marks the just-filled
// word final when nothing is left over. No word is sent for an empty flush.
// Both channels move an item at an edge where valid and ready are high.
// An item held in the input register passes to the core once the queue
// has room; its words are registered in the result queue, then offered.
// Throughput: one item per cycle while each item yields at most one word
// and the queue has room; the output side moves one word per cycle while
// the receiver is ready, so an item that yields two words needs two transfers.
// A four-entry result queue decouples the sides; i_in.ready drops only when
// it has fewer than two free entries and the input register is occupied.
// Reset (i_rst_n low at a clock edge) empties the queue and clears the
// partial word and bit offset. A stalled receiver holds the queue head
// steady and back-pressures the input once the queue fills.
module variable_bit_packer #(
    parameter int WORD_BITS = vbp_pkg::DEF_WORD_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vbp_in_if.sink       i_in,
    vbp_out_if.source    o_out
);

    logic                       r_in_vld;
    logic [vbp_pkg::DATA_W-1:0] r_chunk;
    logic [vbp_pkg::CNT_W-1:0]  r_chunk_bits;
    logic                       r_end;

    logic             room;
    logic             fire;
    logic             in_take;
    vbp_pkg::t_push   push;
    vbp_pkg::t_result head;

    assign fire       = r_in_vld && room;
    assign i_in.ready = !r_in_vld || room;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_chunk      <= i_in.chunk;
            r_chunk_bits <= i_in.chunk_bits;
            r_end        <= i_in.end_of_string;
        end
    end

    vbp_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_chunk      (r_chunk),
        .i_chunk_bits (r_chunk_bits),
        .i_end        (r_end),
        .o_push       (push)
    );

    vbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (head)
    );

    assign o_out.packed_word = head.packed_word;
    assign o_out.bits_used   = head.bits_used;
    assign o_out.final_res   = head.final_res;

endmodule
